// ===== hdl/omb_pkg.sv =====
`timescale 1ns / 1ps

package omb_pkg;

    localparam int ADDR_W   = 48;
    localparam int LIVE_W   = 17;
    localparam int SIZE_W   = 17;
    localparam logic [LIVE_W-1:0] LIVE_MAX = '1;

    typedef enum logic [0:0] {
        KIND_MARK  = 1'b0,
        KIND_COUNT = 1'b1
    } kind_t;

    typedef struct packed {
        logic              kind;
        logic [ADDR_W-1:0] start_addr;
        logic [SIZE_W-1:0] obj_words;
        logic [ADDR_W-1:0] end_obj_addr;
    } req_t;

    typedef struct packed {
        logic              newly_marked;
        logic [LIVE_W-1:0] live_words;
        logic              error;
    } rsp_t;

    typedef struct packed {
        logic              kind;
        logic              err;
        logic [ADDR_W-1:0] a_off;
        logic [ADDR_W-1:0] b_val;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MARK_RD,
        ST_MARK_WR,
        ST_CNT_RD,
        ST_CNT_SCAN,
        ST_DONE
    } back_state_t;

endpackage

// ===== hdl/omb_front.sv =====
`timescale 1ns / 1ps

module omb_front
    import omb_pkg::*;
#(
    parameter int HEAP_WORDS = 65536
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [ADDR_W-1:0] cfg_wdata,
    input  logic              req_valid,
    output logic              req_stall,
    input  req_t              req,
    input  logic              q_full,
    input  logic              clearing,
    output logic              push,
    output cmd_t              cmd
);

    localparam logic [ADDR_W-1:0] HEAP_LIM = ADDR_W'(HEAP_WORDS);

    logic [ADDR_W-1:0] base_reg;
    logic [ADDR_W-1:0] off_a;
    logic [ADDR_W-1:0] off_e;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
        end
        else if (cfg_we)
        begin
            base_reg <= cfg_wdata;
        end
    end

    assign req_stall = q_full || clearing;
    assign push      = req_valid && !req_stall;
    assign off_a     = req.start_addr - base_reg;
    assign off_e     = req.end_obj_addr - base_reg;

    always_comb
    begin
        cmd.kind  = req.kind;
        cmd.a_off = off_a;
        if (req.kind == KIND_COUNT)
        begin
            cmd.b_val = off_e;
            cmd.err   = (off_a >= HEAP_LIM) || (off_e >= HEAP_LIM);
        end
        else
        begin
            cmd.b_val = ADDR_W'(req.obj_words);
            cmd.err   = (off_a >= HEAP_LIM) || (req.obj_words == '0);
        end
    end

endmodule

// ===== hdl/omb_queue.sv =====
`timescale 1ns / 1ps

module omb_queue
    import omb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_data,
    input  logic pop,
    output logic full,
    output logic empty,
    output cmd_t head
);

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;

    assign full  = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign head  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

endmodule

// ===== hdl/omb_back.sv =====
`timescale 1ns / 1ps

module omb_back
    import omb_pkg::*;
#(
    parameter int HEAP_WORDS    = 65536,
    parameter int MAP_WORD_BITS = 64
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic q_empty,
    input  cmd_t head,
    output logic pop,
    output logic clearing,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int OFF_W  = $clog2(HEAP_WORDS);
    localparam int BIT_W  = $clog2(MAP_WORD_BITS);
    localparam int ROWS   = (HEAP_WORDS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int LAST_W = ((OFF_W > SIZE_W) ? OFF_W : SIZE_W) + 1;
    localparam int DIFF_W = OFF_W + 1;
    localparam int SUM_W  = ((DIFF_W > LIVE_W) ? DIFF_W : LIVE_W) + 1;
    localparam logic [OFF_W-1:0] BIT_MASK = OFF_W'(MAP_WORD_BITS - 1);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);
    localparam logic [LAST_W-1:0] HEAP_LIM = LAST_W'(HEAP_WORDS);

    logic [MAP_WORD_BITS-1:0] bmem [ROWS];
    logic [MAP_WORD_BITS-1:0] emem [ROWS];
    logic [MAP_WORD_BITS-1:0] brd_reg;
    logic [MAP_WORD_BITS-1:0] erd_reg;

    back_state_t       state_reg, state_next;
    logic [ROW_W-1:0]  clr_reg, clr_next;
    logic [OFF_W-1:0]  beg_reg, beg_next;
    logic [OFF_W-1:0]  last_reg, last_next;
    logic [OFF_W-1:0]  eoff_reg, eoff_next;
    logic [OFF_W-1:0]  pos_reg, pos_next;
    logic [OFF_W-1:0]  obj_reg, obj_next;
    logic              seek_end_reg, seek_end_next;
    logic [LIVE_W-1:0] live_reg, live_next;
    rsp_t              res_reg, res_next;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_t              rsp_reg, rsp_next;

    logic                     rd_en;
    logic [ROW_W-1:0]         rd_b, rd_e;
    logic                     we_b, we_e;
    logic [ROW_W-1:0]         wa_b, wa_e;
    logic [MAP_WORD_BITS-1:0] wd_b, wd_e;

    logic [LAST_W-1:0]        last_full;
    logic                     last_row;
    logic [MAP_WORD_BITS-1:0] hits;
    logic                     any_hit;
    logic [BIT_W-1:0]         hit_k;
    logic [OFF_W-1:0]         hit_pos;
    logic [DIFF_W-1:0]        obj_len;
    logic [SUM_W-1:0]         sum;

    assign clearing  = (state_reg == ST_CLEAR);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            brd_reg <= bmem[rd_b];
            erd_reg <= emem[rd_e];
        end
        if (we_b)
        begin
            bmem[wa_b] <= wd_b;
        end
        if (we_e)
        begin
            emem[wa_e] <= wd_e;
        end
    end

    assign last_full = LAST_W'(head.a_off[OFF_W-1:0]) + LAST_W'(head.b_val[SIZE_W-1:0])
                       - LAST_W'(1);
    assign last_row  = ((pos_reg >> BIT_W) == (eoff_reg >> BIT_W));

    always_comb
    begin
        for (int i = 0; i < MAP_WORD_BITS; i++)
        begin
            hits[i] = (seek_end_reg ? erd_reg[i] : brd_reg[i])
                      && (BIT_W'(i) >= pos_reg[BIT_W-1:0])
                      && (!last_row || (BIT_W'(i) < eoff_reg[BIT_W-1:0]));
        end
        hit_k = '0;
        for (int i = MAP_WORD_BITS - 1; i >= 0; i--)
        begin
            if (hits[i])
            begin
                hit_k = BIT_W'(i);
            end
        end
    end

    assign any_hit = |hits;
    assign hit_pos = (pos_reg & ~BIT_MASK) | OFF_W'(hit_k);
    assign obj_len = DIFF_W'(hit_pos) - DIFF_W'(obj_reg) + DIFF_W'(1);
    assign sum     = SUM_W'(live_reg) + SUM_W'(obj_len);

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        beg_next       = beg_reg;
        last_next      = last_reg;
        eoff_next      = eoff_reg;
        pos_next       = pos_reg;
        obj_next       = obj_reg;
        seek_end_next  = seek_end_reg;
        live_next      = live_reg;
        res_next       = res_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        pop            = 1'b0;
        rd_en          = 1'b0;
        rd_b           = ROW_W'(beg_reg >> BIT_W);
        rd_e           = ROW_W'(last_reg >> BIT_W);
        we_b           = 1'b0;
        we_e           = 1'b0;
        wa_b           = ROW_W'(beg_reg >> BIT_W);
        wa_e           = ROW_W'(last_reg >> BIT_W);
        wd_b           = brd_reg | (MAP_WORD_BITS'(1) << beg_reg[BIT_W-1:0]);
        wd_e           = erd_reg | (MAP_WORD_BITS'(1) << last_reg[BIT_W-1:0]);

        case (state_reg)
            ST_CLEAR:
            begin
                we_b = 1'b1;
                we_e = 1'b1;
                wa_b = clr_reg;
                wa_e = clr_reg;
                wd_b = '0;
                wd_e = '0;
                clr_next = clr_reg + ROW_W'(1);
                if (clr_reg == ROW_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    pop      = 1'b1;
                    res_next = '0;
                    beg_next = head.a_off[OFF_W-1:0];
                    last_next = OFF_W'(last_full);
                    eoff_next = head.b_val[OFF_W-1:0];
                    pos_next  = head.a_off[OFF_W-1:0];
                    obj_next  = '0;
                    seek_end_next = 1'b0;
                    live_next = '0;
                    if (head.err)
                    begin
                        res_next.error = 1'b1;
                        state_next = ST_DONE;
                    end
                    else if (head.kind == KIND_MARK)
                    begin
                        if (last_full >= HEAP_LIM)
                        begin
                            res_next.error = 1'b1;
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            state_next = ST_MARK_RD;
                        end
                    end
                    else if (head.a_off[OFF_W-1:0] > head.b_val[OFF_W-1:0])
                    begin
                        res_next.error = 1'b1;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_CNT_RD;
                    end
                end
            end
            ST_MARK_RD:
            begin
                rd_en = 1'b1;
                state_next = ST_MARK_WR;
            end
            ST_MARK_WR:
            begin
                if (!brd_reg[beg_reg[BIT_W-1:0]])
                begin
                    we_b = 1'b1;
                    we_e = 1'b1;
                    res_next.newly_marked = 1'b1;
                end
                state_next = ST_DONE;
            end
            ST_CNT_RD:
            begin
                rd_en = 1'b1;
                rd_b  = ROW_W'(pos_reg >> BIT_W);
                rd_e  = ROW_W'(pos_reg >> BIT_W);
                state_next = ST_CNT_SCAN;
            end
            ST_CNT_SCAN:
            begin
                if (!any_hit)
                begin
                    if (last_row)
                    begin
                        if (seek_end_reg || !brd_reg[eoff_reg[BIT_W-1:0]])
                        begin
                            res_next.error = 1'b1;
                        end
                        else
                        begin
                            res_next.live_words = live_reg;
                        end
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        pos_next   = (pos_reg | BIT_MASK) + OFF_W'(1);
                        state_next = ST_CNT_RD;
                    end
                end
                else if (!seek_end_reg)
                begin
                    obj_next      = hit_pos;
                    pos_next      = hit_pos;
                    seek_end_next = 1'b1;
                end
                else
                begin
                    live_next     = (sum > SUM_W'(LIVE_MAX)) ? LIVE_MAX : LIVE_W'(sum);
                    seek_end_next = 1'b0;
                    pos_next      = hit_pos + OFF_W'(1);
                    if (hit_k == BIT_W'(MAP_WORD_BITS - 1))
                    begin
                        state_next = ST_CNT_RD;
                    end
                end
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = res_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        beg_reg      <= beg_next;
        last_reg     <= last_next;
        eoff_reg     <= eoff_next;
        pos_reg      <= pos_next;
        obj_reg      <= obj_next;
        seek_end_reg <= seek_end_next;
        live_reg     <= live_next;
        res_reg      <= res_next;
        rsp_reg      <= rsp_next;
    end

endmodule

// ===== hdl/object_mark_bitmap.sv =====
`timescale 1ns / 1ps
// Begin/end mark bitmaps over a heap region, one bit per heap word.
// Request channel (req_valid/req_stall/req): kind 0 marks the object at
// start_addr of obj_words words; kind 1 counts live words from start_addr up
// to the marked object at end_obj_addr. Every request yields one response
// beat on rsp_valid/rsp_stall/rsp with newly_marked, live_words and error.
// cfg_we/cfg_wdata write region_base; write only while the block is idle.
// Requests pass a two-entry queue to the execution side, so requests keep
// flowing in, until the queue fills, while a response waits for the receiver.
// A mark reads the bitmap rows of its first and last word, then sets both
// marks if the begin bit was clear; a count reads each bitmap row spanned
// in turn and finds one begin or end mark per scan step, as each bitmap
// memory has a single read port. After reset both bitmaps are cleared,
// one row per cycle through every row; req_stall stays high meanwhile.
// While rsp_stall is high the response holds; the queue fills and then
// req_stall rises.

module object_mark_bitmap
    import omb_pkg::*;
#(
    parameter int HEAP_WORDS    = 65536,
    parameter int MAP_WORD_BITS = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [ADDR_W-1:0] cfg_wdata,
    input  logic              req_valid,
    output logic              req_stall,
    input  req_t              req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output rsp_t              rsp
);

    logic q_full;
    logic q_empty;
    logic push;
    logic pop;
    logic clearing;
    cmd_t cmd;
    cmd_t head;

    omb_front #(
        .HEAP_WORDS (HEAP_WORDS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .q_full    (q_full),
        .clearing  (clearing),
        .push      (push),
        .cmd       (cmd)
    );

    omb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (cmd),
        .pop       (pop),
        .full      (q_full),
        .empty     (q_empty),
        .head      (head)
    );

    omb_back #(
        .HEAP_WORDS    (HEAP_WORDS),
        .MAP_WORD_BITS (MAP_WORD_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .head      (head),
        .pop       (pop),
        .clearing  (clearing),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule
